// ----- hw/rtl/tcpu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Teaching CPU execute unit package
// Sizes, word and address types, command codes and controller states shared
// by the execute unit.
// ----------------------------------------------------------------------------
package tcpu_pkg;

    localparam int MEM_WORDS = 256;
    localparam int WORD_BITS = 16;
    localparam int REG_COUNT = 16;
    localparam int IO_BITS   = 16;
    localparam int ADDR_BITS = $clog2(MEM_WORDS);
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    localparam logic [3:0] PC_REG = 4'd15;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [ADDR_BITS-1:0] t_maddr;

    typedef enum logic [3:0] {
        CMD_LOAD  = 4'd0,
        CMD_STORE = 4'd1,
        CMD_ADD   = 4'd2,
        CMD_SUB   = 4'd3,
        CMD_MUL   = 4'd4,
        CMD_DIV   = 4'd5,
        CMD_LDIND = 4'd6,
        CMD_STIND = 4'd7,
        CMD_BR    = 4'd8,
        CMD_BRZ   = 4'd9,
        CMD_BRN   = 4'd10,
        CMD_BRP   = 4'd11,
        CMD_READ  = 4'd12,
        CMD_WRITE = 4'd13,
        CMD_SKIP  = 4'd14,
        CMD_HALT  = 4'd15
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_IND,
        ST_DIV
    } t_state;

endpackage

// ----- hw/rtl/teaching_cpu_execute_unit_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Teaching CPU execute unit
// Executes one decoded instruction per command word on a sixteen-entry
// register file (entry 15 is the program counter) and a cleared data memory.
//
//   channel   handshake            signals
//   command   start / busy         i_command, i_reg_a, i_reg_b, i_reg_dest,
//                                  i_address, i_input_value
//   result    o_done (one cycle)   o_pc_value, o_out_value, o_out_valid,
//                                  o_halted, o_error
//
// Most commands first read the register file and data memory port, then
// modify and write back. Indirect load adds a step for its second memory
// read, and divide runs the bit-serial divider before its write-back.
// The result word appears the cycle after the last write, and a new
// command may be started in that same cycle. Reset clears both stores at once
// through per-entry valid bits, so no clearing pass follows reset. The
// receiver cannot stall the result.
// ----------------------------------------------------------------------------
module teaching_cpu_execute_unit_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [3:0]                          i_command,
    input  logic [3:0]                          i_reg_a,
    input  logic [3:0]                          i_reg_b,
    input  logic [3:0]                          i_reg_dest,
    input  logic [7:0]                          i_address,
    input  logic signed [tcpu_pkg::IO_BITS-1:0] i_input_value,
    output logic                                o_done,
    output logic [tcpu_pkg::IO_BITS-1:0]        o_pc_value,
    output logic signed [tcpu_pkg::IO_BITS-1:0] o_out_value,
    output logic                                o_out_valid,
    output logic                                o_halted,
    output logic                                o_error
);
    import tcpu_pkg::*;

    // Control state.
    t_state r_state, n_state;
    t_word  r_pc;
    logic   r_halt;
    logic   r_done;
    logic [REG_COUNT-1:0] r_rf_valid;
    logic [MEM_WORDS-1:0] r_mem_valid;
    logic [CNT_BITS-1:0]  r_div_cnt;

    // Latched command word.
    t_cmd       r_cmd;
    logic [3:0] r_ra, r_rb, r_rd;
    logic [7:0] r_addr;
    t_word      r_in;

    // Stores and their registered read data.
    t_word rf_mem [REG_COUNT];
    t_word data_mem [MEM_WORDS];
    t_word r_rf_a, r_rf_b, r_mem_q;

    // Divider.
    t_word r_div_rem, r_div_quo, r_div_den;
    logic  r_div_neg;

    // Result registers.
    logic [IO_BITS-1:0] r_out_value;
    logic               r_out_valid;
    logic               r_error;

    // Combinational signals.
    logic   accept;
    t_word  op_a, op_b, a_mag, b_mag;
    logic   dir_ok, ptr_ok;
    t_maddr mem_dir, mem_ptr, mem_ra, mem_wa;
    logic   mem_re, mem_we;
    t_word  mem_wd;
    logic signed [2*WORD_BITS-1:0] prod;
    logic [WORD_BITS:0] div_shift, div_trial;
    logic   div_bit, div_last;
    t_word  div_rem_nx, div_q, div_res;
    logic   wr_req, adv, br_take, fin, err, outv_en, ind_go, div_go, halt_set;
    logic [3:0] wr_tgt;
    t_word  wr_val;
    logic   rf_we, pc_we;
    t_word  pc_wd;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    // Register 15 lives in r_pc; it never changes while a command is in flight.
    assign op_a = (r_ra == PC_REG) ? r_pc : r_rf_a;
    assign op_b = (r_rb == PC_REG) ? r_pc : r_rf_b;

    assign mem_dir = t_maddr'(r_addr);
    assign mem_ptr = t_maddr'(r_mem_q);
    assign dir_ok  = (int'(r_addr) < MEM_WORDS);
    assign ptr_ok  = !r_mem_q[WORD_BITS-1] && (64'(r_mem_q) < 64'(MEM_WORDS));

    assign prod  = $signed(op_a) * $signed(op_b);
    assign a_mag = op_a[WORD_BITS-1] ? t_word'(-op_a) : op_a;
    assign b_mag = op_b[WORD_BITS-1] ? t_word'(-op_b) : op_b;

    // One restoring-division step per cycle on magnitudes.
    assign div_shift  = {r_div_rem, r_div_quo[WORD_BITS-1]};
    assign div_trial  = div_shift - {1'b0, r_div_den};
    assign div_bit    = !div_trial[WORD_BITS];
    assign div_rem_nx = div_bit ? div_trial[WORD_BITS-1:0] : div_shift[WORD_BITS-1:0];
    assign div_q      = {r_div_quo[WORD_BITS-2:0], div_bit};
    assign div_res    = r_div_neg ? t_word'(-div_q) : div_q;
    assign div_last   = (r_div_cnt == CNT_BITS'(WORD_BITS - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (div_go) begin
                    n_state = ST_DIV;
                end else if (ind_go) begin
                    n_state = ST_IND;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_IND: begin
                n_state = ST_IDLE;
            end
            ST_DIV: begin
                if (div_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath control.
    always_comb begin
        wr_req   = 1'b0;
        wr_tgt   = r_ra;
        wr_val   = r_mem_q;
        adv      = 1'b0;
        br_take  = 1'b0;
        fin      = 1'b0;
        err      = 1'b0;
        outv_en  = 1'b0;
        ind_go   = 1'b0;
        div_go   = 1'b0;
        halt_set = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = mem_dir;
        mem_wd   = op_a;
        case (r_state)
            ST_EXEC: begin
                if (r_halt) begin
                    fin = 1'b1;
                end else begin
                    case (r_cmd)
                        CMD_LOAD: begin
                            fin    = 1'b1;
                            err    = !dir_ok;
                            wr_req = dir_ok;
                        end
                        CMD_STORE: begin
                            fin    = 1'b1;
                            err    = !dir_ok;
                            mem_we = dir_ok;
                            adv    = dir_ok;
                        end
                        CMD_ADD: begin
                            fin    = 1'b1;
                            wr_req = 1'b1;
                            wr_tgt = r_rd;
                            wr_val = t_word'(op_a + op_b);
                        end
                        CMD_SUB: begin
                            fin    = 1'b1;
                            wr_req = 1'b1;
                            wr_tgt = r_rd;
                            wr_val = t_word'(op_a - op_b);
                        end
                        CMD_MUL: begin
                            fin    = 1'b1;
                            wr_req = 1'b1;
                            wr_tgt = r_rd;
                            wr_val = t_word'(prod);
                        end
                        CMD_DIV: begin
                            if (op_b == '0) begin
                                fin = 1'b1;
                                err = 1'b1;
                            end else begin
                                div_go = 1'b1;
                            end
                        end
                        CMD_LDIND: begin
                            if (dir_ok && ptr_ok) begin
                                ind_go = 1'b1;
                            end else begin
                                fin = 1'b1;
                                err = 1'b1;
                            end
                        end
                        CMD_STIND: begin
                            fin    = 1'b1;
                            err    = !(dir_ok && ptr_ok);
                            mem_we = dir_ok && ptr_ok;
                            mem_wa = mem_ptr;
                            adv    = dir_ok && ptr_ok;
                        end
                        CMD_BR: begin
                            fin     = 1'b1;
                            br_take = 1'b1;
                        end
                        CMD_BRZ: begin
                            fin     = 1'b1;
                            br_take = (op_a == '0);
                            adv     = (op_a != '0);
                        end
                        CMD_BRN: begin
                            fin     = 1'b1;
                            br_take = op_a[WORD_BITS-1];
                            adv     = !op_a[WORD_BITS-1];
                        end
                        CMD_BRP: begin
                            fin     = 1'b1;
                            br_take = !op_a[WORD_BITS-1];
                            adv     = op_a[WORD_BITS-1];
                        end
                        CMD_READ: begin
                            fin    = 1'b1;
                            wr_req = 1'b1;
                            wr_val = r_in;
                        end
                        CMD_WRITE: begin
                            fin     = 1'b1;
                            outv_en = 1'b1;
                            adv     = 1'b1;
                        end
                        CMD_SKIP: begin
                            fin = 1'b1;
                            adv = 1'b1;
                        end
                        CMD_HALT: begin
                            fin      = 1'b1;
                            halt_set = 1'b1;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_IND: begin
                fin    = 1'b1;
                wr_req = 1'b1;
            end
            ST_DIV: begin
                if (div_last) begin
                    fin    = 1'b1;
                    wr_req = 1'b1;
                    wr_tgt = r_rd;
                    wr_val = div_res;
                end
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    // A result written into register 15 is advanced like any other result.
    assign rf_we = wr_req && (wr_tgt != PC_REG);
    assign pc_we = wr_req || adv || br_take;
    assign pc_wd = br_take                            ? t_word'(r_addr)            :
                   (wr_req && (wr_tgt == PC_REG))     ? t_word'(wr_val + 1'b1)     :
                                                        t_word'(r_pc + 1'b1);

    assign mem_re = accept || ind_go;
    assign mem_ra = (r_state == ST_IDLE) ? t_maddr'(i_address) : mem_ptr;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_halt      <= 1'b0;
            r_done      <= 1'b0;
            r_rf_valid  <= '0;
            r_mem_valid <= '0;
            r_div_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= fin;
            if (pc_we) begin
                r_pc <= pc_wd;
            end
            if (halt_set) begin
                r_halt <= 1'b1;
            end
            if (rf_we) begin
                r_rf_valid[wr_tgt] <= 1'b1;
            end
            if (mem_we) begin
                r_mem_valid[mem_wa] <= 1'b1;
            end
            if (div_go) begin
                r_div_cnt <= '0;
            end else if (r_state == ST_DIV) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
        end
    end

    // Command latch and result registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= t_cmd'(i_command);
            r_ra   <= i_reg_a;
            r_rb   <= i_reg_b;
            r_rd   <= i_reg_dest;
            r_addr <= i_address;
            r_in   <= t_word'(i_input_value);
        end
        if (fin) begin
            r_out_value <= outv_en ? IO_BITS'($signed(op_a)) : '0;
            r_out_valid <= outv_en;
            r_error     <= err;
        end
    end

    // Register file: two read ports, one write port. Entries never written
    // read as zero.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rf_a <= r_rf_valid[i_reg_a] ? rf_mem[i_reg_a] : '0;
            r_rf_b <= r_rf_valid[i_reg_b] ? rf_mem[i_reg_b] : '0;
        end
        if (rf_we) begin
            rf_mem[wr_tgt] <= wr_val;
        end
    end

    // Data memory: one read port, one write port. Reads and writes never
    // share an edge, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_mem_q <= r_mem_valid[mem_ra] ? data_mem[mem_ra] : '0;
        end
        if (mem_we) begin
            data_mem[mem_wa] <= mem_wd;
        end
    end

    // Divider registers.
    always_ff @(posedge i_clk) begin
        if (div_go) begin
            r_div_rem <= '0;
            r_div_quo <= a_mag;
            r_div_den <= b_mag;
            r_div_neg <= op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
        end else if (r_state == ST_DIV) begin
            r_div_rem <= div_rem_nx;
            r_div_quo <= div_q;
        end
    end

    assign o_done      = r_done;
    assign o_pc_value  = IO_BITS'($unsigned(r_pc));
    assign o_out_value = r_out_value;
    assign o_out_valid = r_out_valid;
    assign o_halted    = r_halt;
    assign o_error     = r_error;

    // The result word is shown only after the controller has returned to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Once halted, the unit stays halted until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_halted |=> o_halted)
        else $error("halted flag dropped");

    // A refused command never emits an output word.
    a_err_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_error) |-> !o_out_valid)
        else $error("output word on a refused command");

    // An accepted command makes the unit busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");

    // The divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_div_den != '0))
        else $error("divider running on zero divisor");

endmodule
